[sv/pwmg_pkg.sv]
// package for the multi-channel pwm generator
// holds command and register codes, microcode layout and the control rom
// no dependencies
package pwmg_pkg;

	localparam int CHANNELS = 16;
	localparam int CH_W = $clog2(CHANNELS);
	localparam int WORD_W = 16;
	localparam int LVL_W = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	// 9-bit dividend, one quotient bit per step
	localparam int DIV_W = 9;
	localparam int DIV_STEPS = DIV_W;
	localparam int CNT_W = $clog2(DIV_STEPS);

	localparam logic [LVL_W-1:0] PERIOD_RST = 8'd16;
	localparam logic [DIV_W-1:0] DIVISOR_RST = 9'd16;
	localparam logic [DIV_W-1:0] PERIOD_DIVIDEND = 9'd256;

	localparam logic [1:0] CMD_TICK = 2'd0;
	localparam logic [1:0] CMD_SET = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;
	localparam logic [1:0] CMD_NOP = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_MASK = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd1;

	// micro-ops
	localparam int OP_W = 4;
	localparam logic [OP_W-1:0] OP_NONE = 4'd0;
	localparam logic [OP_W-1:0] OP_TICK_BIT = 4'd1;
	localparam logic [OP_W-1:0] OP_TICK_END = 4'd2;
	localparam logic [OP_W-1:0] OP_SET_INIT = 4'd3;
	localparam logic [OP_W-1:0] OP_DIVL_STEP = 4'd4;
	localparam logic [OP_W-1:0] OP_SET_END = 4'd5;
	localparam logic [OP_W-1:0] OP_READ_END = 4'd6;
	localparam logic [OP_W-1:0] OP_NOP_END = 4'd7;
	localparam logic [OP_W-1:0] OP_PDIV_INIT = 4'd8;
	localparam logic [OP_W-1:0] OP_DIVP_STEP = 4'd9;
	localparam logic [OP_W-1:0] OP_PDIV_END = 4'd10;
	localparam logic [OP_W-1:0] OP_RC_LOAD = 4'd11;
	localparam logic [OP_W-1:0] OP_RC_STORE = 4'd12;

	// jump conditions
	localparam int COND_W = 2;
	localparam logic [COND_W-1:0] COND_NEXT = 2'd0;
	localparam logic [COND_W-1:0] COND_ALWAYS = 2'd1;
	localparam logic [COND_W-1:0] COND_CNT_MORE = 2'd2;
	localparam logic [COND_W-1:0] COND_CHAN_MORE = 2'd3;

	// microcode addresses
	localparam int UA_W = 4;
	localparam logic [UA_W-1:0] UA_IDLE = 4'd0;
	localparam logic [UA_W-1:0] UA_TICK_BIT = 4'd1;
	localparam logic [UA_W-1:0] UA_TICK_END = 4'd2;
	localparam logic [UA_W-1:0] UA_SET_INIT = 4'd3;
	localparam logic [UA_W-1:0] UA_SET_DIV = 4'd4;
	localparam logic [UA_W-1:0] UA_SET_END = 4'd5;
	localparam logic [UA_W-1:0] UA_READ_END = 4'd6;
	localparam logic [UA_W-1:0] UA_NOP_END = 4'd7;
	localparam logic [UA_W-1:0] UA_PDIV_INIT = 4'd8;
	localparam logic [UA_W-1:0] UA_PDIV_STEP = 4'd9;
	localparam logic [UA_W-1:0] UA_PDIV_END = 4'd10;
	localparam logic [UA_W-1:0] UA_RC_LOAD = 4'd11;
	localparam logic [UA_W-1:0] UA_RC_DIV = 4'd12;
	localparam logic [UA_W-1:0] UA_RC_STORE = 4'd13;
	localparam logic [UA_W-1:0] UA_RC_DONE = 4'd14;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic [COND_W-1:0] cond;
		logic [UA_W-1:0] target;
	} uword_t;

	typedef struct packed {
		logic go;
		logic [UA_W-1:0] entry;
	} seq_req_t;

	typedef struct packed {
		logic cnt_more;
		logic chan_more;
	} seq_stat_t;

	function automatic uword_t ucode(input logic [UA_W-1:0] addr);
		uword_t w;
		unique case (addr)
			UA_IDLE: w = '{OP_NONE, COND_ALWAYS, UA_IDLE};
			UA_TICK_BIT: w = '{OP_TICK_BIT, COND_CHAN_MORE, UA_TICK_BIT};
			UA_TICK_END: w = '{OP_TICK_END, COND_ALWAYS, UA_IDLE};
			UA_SET_INIT: w = '{OP_SET_INIT, COND_NEXT, UA_IDLE};
			UA_SET_DIV: w = '{OP_DIVL_STEP, COND_CNT_MORE, UA_SET_DIV};
			UA_SET_END: w = '{OP_SET_END, COND_ALWAYS, UA_IDLE};
			UA_READ_END: w = '{OP_READ_END, COND_ALWAYS, UA_IDLE};
			UA_NOP_END: w = '{OP_NOP_END, COND_ALWAYS, UA_IDLE};
			UA_PDIV_INIT: w = '{OP_PDIV_INIT, COND_NEXT, UA_IDLE};
			UA_PDIV_STEP: w = '{OP_DIVP_STEP, COND_CNT_MORE, UA_PDIV_STEP};
			UA_PDIV_END: w = '{OP_PDIV_END, COND_NEXT, UA_IDLE};
			UA_RC_LOAD: w = '{OP_RC_LOAD, COND_NEXT, UA_IDLE};
			UA_RC_DIV: w = '{OP_DIVL_STEP, COND_CNT_MORE, UA_RC_DIV};
			UA_RC_STORE: w = '{OP_RC_STORE, COND_CHAN_MORE, UA_RC_LOAD};
			UA_RC_DONE: w = '{OP_NONE, COND_ALWAYS, UA_IDLE};
			default: w = '{OP_NONE, COND_ALWAYS, UA_IDLE};
		endcase
		return w;
	endfunction

endpackage

[sv/pwmg_sequencer.sv]
// microcode sequencer: step counter, control rom and conditional jumps
// depends on pwmg_pkg
module pwmg_sequencer import pwmg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  seq_req_t  req,
	input  seq_stat_t stat,
	output uword_t    uw,
	output logic      idle
);

	logic [UA_W-1:0] upc_q;

	assign uw = ucode(upc_q);
	assign idle = (upc_q == UA_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= UA_IDLE;
		end else if (idle) begin
			if (req.go) begin
				upc_q <= req.entry;
			end
		end else begin
			unique case (uw.cond)
				COND_NEXT: upc_q <= upc_q + 1'b1;
				COND_ALWAYS: upc_q <= uw.target;
				COND_CNT_MORE: upc_q <= stat.cnt_more ? uw.target : upc_q + 1'b1;
				COND_CHAN_MORE: upc_q <= stat.chan_more ? uw.target : upc_q + 1'b1;
				default: upc_q <= UA_IDLE;
			endcase
		end
	end

	a_stay_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(idle && !req.go) |=> idle)
		else $error("sequencer left idle without a request");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(idle && req.go) |=> (upc_q == $past(req.entry)))
		else $error("sequencer missed its entry address");

	a_leave: assert property (@(posedge clk) disable iff (!arst_n)
		(idle && req.go) |=> !idle)
		else $error("request did not start a program");

endmodule

[sv/multi_channel_pwm_generator_top.sv]
// top level of the 16-channel pwm generator: datapath, level stores, result registers
// depends on pwmg_pkg and pwmg_sequencer
//
// usage: a command transaction is taken at a clock edge with start high and busy low;
// command 0 is a pwm tick, 1 stores level_in for pin_index, 2 reads back the stored level.
// each command gives one result: done is high for one cycle with pin_levels,
// levels_changed and level_readback valid; the receiver cannot stall it.
// steps after the accepting edge: a tick compares each channel in turn, then closes the
// word; a set stores the level, then runs the 9-step restoring divide for the duty;
// read and the unused command go straight to their end step. busy drops in the cycle
// done is shown, so a new command can follow at once.
// config writes (cfg_valid/cfg_ready) are taken while idle and start is low; writing
// register 1 (period) recomputes the divisor and every enabled pin's scaled duty
// through the same shared divider, holding busy until the recompute is through.
// reset clears the levels, duties, step counter and previous word, mask to 0, period 16.
module multi_channel_pwm_generator_top import pwmg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [1:0]            command,
	input  logic [3:0]            pin_index,
	input  logic [LVL_W-1:0]      level_in,
	output logic                  busy,
	output logic                  done,
	output logic [WORD_W-1:0]     pin_levels,
	output logic                  levels_changed,
	output logic [LVL_W-1:0]      level_readback,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam logic [4:0] CH_LIM = 5'(CHANNELS);
	localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNELS - 1);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

	uword_t    uw;
	seq_req_t  req;
	seq_stat_t stat;
	logic      idle;
	logic      in_acc;
	logic      cfg_acc;

	logic [WORD_W-1:0] mask_q;
	logic [LVL_W-1:0]  period_q;
	logic [DIV_W-1:0]  divisor_q;
	logic [LVL_W-1:0]  ctr_q;
	logic [WORD_W-1:0] prev_q;
	logic [LVL_W-1:0]  level_q [CHANNELS];
	logic [LVL_W-1:0]  duty_q [CHANNELS];

	logic [WORD_W-1:0] word_q;
	logic [CH_W-1:0]   chan_q;
	logic [LVL_W-1:0]  lvl_q;
	logic              pin_ok_q;
	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  quo_q;
	logic [CNT_W-1:0]  cnt_q;

	logic              done_q;
	logic [WORD_W-1:0] res_word_q;
	logic              res_chg_q;
	logic [LVL_W-1:0]  res_rb_q;

	logic [DIV_W-1:0]  dvs;
	logic [DIV_W:0]    rem_sh;
	logic              ge;
	logic [DIV_W:0]    rem_sub;
	logic [LVL_W-1:0]  ctr_inc;
	logic [LVL_W-1:0]  ctr_nxt;

	assign busy = !idle;
	assign in_acc = start && idle;
	assign cfg_ready = idle && !start;
	assign cfg_acc = cfg_valid && cfg_ready;

	always_comb begin
		req.go = in_acc || (cfg_acc && (cfg_index == REG_PERIOD));
		req.entry = UA_PDIV_INIT;
		if (in_acc) begin
			unique case (command)
				CMD_TICK: req.entry = UA_TICK_BIT;
				CMD_SET: req.entry = UA_SET_INIT;
				CMD_READ: req.entry = UA_READ_END;
				CMD_NOP: req.entry = UA_NOP_END;
				default: req.entry = UA_NOP_END;
			endcase
		end
	end

	assign stat.cnt_more = (cnt_q != CNT_LAST);
	assign stat.chan_more = (chan_q != CH_LAST);

	pwmg_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.stat   (stat),
		.uw     (uw),
		.idle   (idle)
	);

	// shared restoring divider step
	always_comb begin
		if (uw.op == OP_DIVP_STEP) begin
			dvs = (period_q == '0) ? DIV_W'(1) : {1'b0, period_q};
		end else begin
			dvs = divisor_q;
		end
		rem_sh = {rem_q, quo_q[DIV_W-1]};
		ge = (rem_sh >= {1'b0, dvs});
		rem_sub = rem_sh - {1'b0, dvs};
	end

	always_comb begin
		ctr_inc = ctr_q + 1'b1;
		if ((period_q == '0) || (ctr_inc >= (period_q - 1'b1))) begin
			ctr_nxt = '0;
		end else begin
			ctr_nxt = ctr_inc;
		end
	end

	// control state and level stores
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
			period_q <= PERIOD_RST;
			divisor_q <= DIVISOR_RST;
			ctr_q <= '0;
			prev_q <= '0;
			done_q <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				level_q[i] <= '0;
				duty_q[i] <= '0;
			end
		end else begin
			done_q <= 1'b0;
			if (cfg_acc) begin
				unique case (cfg_index)
					REG_MASK: mask_q <= cfg_data[WORD_W-1:0];
					REG_PERIOD: period_q <= cfg_data[LVL_W-1:0];
					default: ;
				endcase
			end
			unique case (uw.op) inside
				OP_TICK_END: begin
					prev_q <= word_q;
					ctr_q <= ctr_nxt;
					done_q <= 1'b1;
				end
				OP_SET_INIT: begin
					if (pin_ok_q) begin
						level_q[chan_q] <= lvl_q;
					end
				end
				OP_SET_END: begin
					if (pin_ok_q) begin
						duty_q[chan_q] <= quo_q[LVL_W-1:0];
					end
					done_q <= 1'b1;
				end
				OP_READ_END, OP_NOP_END: done_q <= 1'b1;
				OP_PDIV_END: divisor_q <= quo_q;
				OP_RC_STORE: begin
					if (mask_q[chan_q]) begin
						duty_q[chan_q] <= quo_q[LVL_W-1:0];
					end
				end
				default: ;
			endcase
		end
	end

	// datapath working registers and result registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			chan_q <= (command == CMD_TICK) ? '0 : pin_index[CH_W-1:0];
			word_q <= '0;
			lvl_q <= level_in;
			pin_ok_q <= ({1'b0, pin_index} < CH_LIM);
		end
		unique case (uw.op) inside
			OP_TICK_BIT: begin
				word_q[chan_q] <= mask_q[chan_q] && (ctr_q < duty_q[chan_q]);
				chan_q <= chan_q + 1'b1;
			end
			OP_TICK_END: begin
				res_word_q <= word_q;
				res_chg_q <= (word_q != prev_q);
				res_rb_q <= '0;
			end
			OP_SET_INIT: begin
				rem_q <= '0;
				quo_q <= {1'b0, lvl_q};
				cnt_q <= '0;
			end
			OP_DIVL_STEP, OP_DIVP_STEP: begin
				rem_q <= ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], ge};
				cnt_q <= cnt_q + 1'b1;
			end
			OP_SET_END: begin
				res_word_q <= prev_q;
				res_chg_q <= 1'b0;
				res_rb_q <= pin_ok_q ? lvl_q : '0;
			end
			OP_READ_END: begin
				res_word_q <= prev_q;
				res_chg_q <= 1'b0;
				res_rb_q <= pin_ok_q ? level_q[chan_q] : '0;
			end
			OP_NOP_END: begin
				res_word_q <= prev_q;
				res_chg_q <= 1'b0;
				res_rb_q <= '0;
			end
			OP_PDIV_INIT: begin
				rem_q <= '0;
				quo_q <= PERIOD_DIVIDEND;
				cnt_q <= '0;
			end
			OP_PDIV_END: chan_q <= '0;
			OP_RC_LOAD: begin
				rem_q <= '0;
				quo_q <= {1'b0, level_q[chan_q]};
				cnt_q <= '0;
			end
			OP_RC_STORE: chan_q <= chan_q + 1'b1;
			default: ;
		endcase
	end

	assign done = done_q;
	assign pin_levels = res_word_q;
	assign levels_changed = res_chg_q;
	assign level_readback = res_rb_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while still busy");

	a_chg_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(levels_changed) |-> done)
		else $error("levels_changed without a result");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted command did not raise busy");

	a_period_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready && (cfg_index == REG_PERIOD)) |=> busy)
		else $error("period write did not start the duty recompute");

endmodule
